// ----- sv/mef_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time block.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package mef_pkg;

  localparam int START_W = 10;
  localparam int ROUND_W = 3;
  localparam int ITER_W  = 12;
  localparam int SLOT_W  = 3;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_BASE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COORD_STEP = 2'd3;

  typedef struct packed {
    logic [START_W-1:0] chunk_start;
    logic [ROUND_W-1:0] round;
  } in_t;

  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [ITER_W-1:0] max_iter;
    logic [WORD_W-1:0] real_base;
    logic [WORD_W-1:0] imag_base;
    logic [WORD_W-1:0] coord_step;
  } cfg_t;

  // one request to the shared multiplier
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              frac;  // 1: shift product right by the fraction width
  } mul_req_t;

endpackage

`default_nettype wire

// ----- sv/mef_cfg.sv -----
// Configuration register bank for the escape-time block.
// Depends on mef_pkg (cfg_t, register indexes).
`timescale 1ns / 1ps
`default_nettype none

module mef_cfg import mef_pkg::*; #(
  parameter int COL_BITS  = 5,
  parameter int FRAC_BITS = 28
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  output cfg_t                      cfg_o
);

  localparam logic [ITER_W-1:0] RST_MAX_ITER = ITER_W'(100);
  localparam logic [WORD_W-1:0] RST_REAL = WORD_W'(0) - (WORD_W'(3) << (FRAC_BITS - 1));
  localparam logic [WORD_W-1:0] RST_IMAG = WORD_W'(0) - (WORD_W'(1) << FRAC_BITS);
  localparam logic [WORD_W-1:0] RST_STEP = (WORD_W'(2) << FRAC_BITS) >> COL_BITS;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iter   <= RST_MAX_ITER;
      cfg_q.real_base  <= RST_REAL;
      cfg_q.imag_base  <= RST_IMAG;
      cfg_q.coord_step <= RST_STEP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_ITER:   cfg_q.max_iter   <= cfg_data_i[ITER_W-1:0];
        REG_REAL_BASE:  cfg_q.real_base  <= cfg_data_i;
        REG_IMAG_BASE:  cfg_q.imag_base  <= cfg_data_i;
        REG_COORD_STEP: cfg_q.coord_step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/mef_smul.sv -----
// Shared sign-magnitude multiplier with registered product.
// Depends on mef_pkg (mul_req_t). Result truncates toward zero.
`timescale 1ns / 1ps
`default_nettype none

module mef_smul import mef_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  wire logic              clk_i,
  input  wire mul_req_t          req_i,
  output logic [WORD_W-1:0]      prod_o
);

  logic [WORD_W-1:0]   mag_a, mag_b, res_d, prod_q;
  logic [2*WORD_W-1:0] full, shifted;
  logic                neg;

  always_comb begin
    // most negative value maps to 2^31, which the unsigned magnitude holds
    mag_a   = req_i.a[WORD_W-1] ? (WORD_W'(0) - req_i.a) : req_i.a;
    mag_b   = req_i.b[WORD_W-1] ? (WORD_W'(0) - req_i.b) : req_i.b;
    neg     = req_i.a[WORD_W-1] ^ req_i.b[WORD_W-1];
    full    = {{WORD_W{1'b0}}, mag_a} * {{WORD_W{1'b0}}, mag_b};
    shifted = req_i.frac ? (full >> FRAC_BITS) : full;
    res_d   = neg ? (WORD_W'(0) - shifted[WORD_W-1:0]) : shifted[WORD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= res_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- sv/mandelbrot_escape_fixed.sv -----
// Mandelbrot escape-time block: one transaction in, POINTS_PER_ITEM counts out.
// Per point: S_CR and S_CI form the coordinate, each iteration runs S_IT0..S_IT3
// through the one shared multiplier, a point ends at the limit check or the escape
// test, and S_OUT hands its count to the output register.
// Input stalls from acceptance until the last result is loaded in the output reg.
// Reset (async, active low) clears control state and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_fixed import mef_pkg::*; #(
  parameter int POINTS_PER_ITEM = 8,
  parameter int COL_BITS        = 5,
  parameter int FRAC_BITS       = 28
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_data_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_data_o
);

  // point counter width
  localparam int PW = (POINTS_PER_ITEM > 1) ? $clog2(POINTS_PER_ITEM) : 1;
  // pixel index width: largest index is start max + last slot + points * round max
  localparam int IDX_MAX = (2 ** START_W - 1) + (POINTS_PER_ITEM - 1)
                           + POINTS_PER_ITEM * (2 ** ROUND_W - 1);
  localparam int IDX_RAW = $clog2(IDX_MAX + 1);
  localparam int IDX_W   = (IDX_RAW > COL_BITS) ? IDX_RAW : COL_BITS + 1;
  // escape threshold 4.0, held wide enough that it never wraps
  localparam logic signed [WORD_W+1:0] LIMIT = (WORD_W + 2)'(4) <<< FRAC_BITS;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CR   = 4'd1;  // col * step
  localparam logic [3:0] S_CI   = 4'd2;  // load cr, row * step
  localparam logic [3:0] S_CZ   = 4'd3;  // load ci, then as S_IT0
  localparam logic [3:0] S_IT0  = 4'd4;  // limit check, zr * zr
  localparam logic [3:0] S_IT1  = 4'd5;  // latch rr, zi * zi
  localparam logic [3:0] S_IT2  = 4'd6;  // escape test, new zr, zr * zi
  localparam logic [3:0] S_IT3  = 4'd7;  // new zi, count up
  localparam logic [3:0] S_OUT  = 4'd8;  // hand result to output register

  logic [3:0]          state_q, state_d;
  logic [START_W-1:0]  start_q;
  logic [ROUND_W-1:0]  round_q;
  logic [PW-1:0]       p_q;
  logic [ITER_W-1:0]   count_q;
  logic [WORD_W-1:0]   cr_q, ci_q, zr_q, zi_q, rr_q;
  logic                out_valid_q;
  out_t                out_q;

  cfg_t                cfg;
  mul_req_t            mreq;
  logic [WORD_W-1:0]   prod;

  logic [IDX_W-1:0]    idx;
  logic [WORD_W-1:0]   col_w, row_w, mag_sum;
  logic [WORD_W+1:0]   sum_ext;
  logic                in_acc, out_load, is_last, escaped;
  logic [6:0]          p_ext;

  mef_cfg #(
    .COL_BITS  (COL_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mef_smul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // pixel index of the current slot and its column / row
  assign idx   = IDX_W'(start_q) + IDX_W'(p_q)
                 + IDX_W'(round_q) * IDX_W'(POINTS_PER_ITEM);
  assign col_w = WORD_W'(idx[COL_BITS-1:0]);
  assign row_w = WORD_W'(idx >> COL_BITS);

  assign is_last = (p_q == PW'(POINTS_PER_ITEM - 1));
  assign p_ext   = 7'(p_q);

  // |z|^2 from the wrapped 32-bit sum, read as signed
  assign mag_sum = rr_q + prod;
  assign sum_ext = {{2{mag_sum[WORD_W-1]}}, mag_sum};
  assign escaped = $signed(sum_ext) > LIMIT;

  // output register loads in S_OUT when empty or being drained
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // multiplier operand selection
  always_comb begin
    mreq = '{a: zr_q, b: zr_q, frac: 1'b1};
    case (state_q)
      S_CR:  mreq = '{a: col_w, b: cfg.coord_step, frac: 1'b0};
      S_CI:  mreq = '{a: row_w, b: cfg.coord_step, frac: 1'b0};
      S_IT1: mreq = '{a: zi_q, b: zi_q, frac: 1'b1};
      S_IT2: mreq = '{a: zr_q, b: zi_q, frac: 1'b1};
      default: ;
    endcase
  end

  // next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_CR;
      S_CR:   state_d = S_CI;
      S_CI:   state_d = S_CZ;
      S_CZ, S_IT0: begin
        state_d = (count_q >= cfg.max_iter) ? S_OUT : S_IT1;
      end
      S_IT1:  state_d = S_IT2;
      S_IT2:  state_d = escaped ? S_OUT : S_IT3;
      S_IT3:  state_d = S_IT0;
      S_OUT: begin
        if (out_load) state_d = is_last ? S_IDLE : S_CR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          start_q <= in_data_i.chunk_start;
          round_q <= in_data_i.round;
          p_q     <= '0;
        end
      end
      S_CR: count_q <= '0;
      S_CI: begin
        cr_q <= cfg.real_base + prod;
        zr_q <= cfg.real_base + prod;
      end
      S_CZ: begin
        ci_q <= cfg.imag_base + prod;
        zi_q <= cfg.imag_base + prod;
      end
      S_IT1: rr_q <= prod;
      S_IT2: begin
        if (!escaped) zr_q <= rr_q - prod + cr_q;
      end
      S_IT3: begin
        zi_q    <= {prod[WORD_W-2:0], 1'b0} + ci_q;
        count_q <= count_q + ITER_W'(1);
      end
      S_OUT: begin
        if (out_load) begin
          out_q.iter_count <= count_q;
          out_q.slot       <= p_ext[SLOT_W-1:0];
          out_q.last       <= is_last;
          if (!is_last) p_q <= p_q + PW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/mef_checker.sv -----
// Port-level checks for the escape-time block, bound to its top level.
// Depends on mef_pkg (out_t) and mandelbrot_escape_fixed.
`timescale 1ns / 1ps
`default_nettype none

module mef_checker import mef_pkg::*; #(
  parameter int POINTS_PER_ITEM = 8
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an accepted transaction blocks the input while its points are worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // the closing result of a group sits in the last slot
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.slot == SLOT_W'(POINTS_PER_ITEM - 1))
    else $error("last flag on wrong slot");

  // once idle, only the group's final result may still be waiting
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> out_data_o.last)
    else $error("idle with an unfinished group pending");

endmodule

bind mandelbrot_escape_fixed mef_checker #(
  .POINTS_PER_ITEM (POINTS_PER_ITEM)
) u_mef_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
